// ===== sv/imuoc_pkg.sv =====
// Shared types, constants and helpers for the six-axis offset calibrator.
package imuoc_pkg;

    // Averaging round shape
    localparam int AVG_COUNT = 50;
    localparam int DISCARD   = 30;

    // Sample index runs 0 .. AVG_COUNT + DISCARD within a round
    localparam int SIDX_END = AVG_COUNT + DISCARD;
    localparam int SIDX_W   = $clog2(SIDX_END + 1);

    // Sum magnitude and signed sum widths
    localparam int MAGS_W = $clog2(AVG_COUNT * 32768 + 1);
    localparam int SUM_W  = MAGS_W + 1;

    // Mean by reciprocal: (x * MEAN_RECIP) >> MEAN_SHIFT is the truncated x / AVG_COUNT
    // for every x below 2**MAGS_W
    localparam int     MEAN_SHIFT = MAGS_W + $clog2(AVG_COUNT);
    localparam longint MEAN_RECIP = ((longint'(1) << MEAN_SHIFT) + AVG_COUNT - 1) / AVG_COUNT;
    localparam int     RECIP_W    = $clog2(MEAN_RECIP + 1);
    localparam int     PROD_W     = MAGS_W + RECIP_W;

    // Divisor width: covers the gyro deadzone plus one
    localparam int DVS_W    = 9;
    localparam int DIVCNT_W = $clog2(MAGS_W);

    // Mean magnitude width (largest value is 32768)
    localparam int MAG_W = 16;

    localparam int NUM_AXES  = 6;
    localparam int NUM_ACCEL = 3;

    // Register reset values
    localparam logic [7:0] ACCEL_DZ_RST   = 8'd20;
    localparam logic [7:0] GYRO_DZ_RST    = 8'd3;
    localparam logic [3:0] MAX_ROUNDS_RST = 4'd11;

    // Register indexes
    localparam logic [1:0] CFG_ACCEL_DZ   = 2'd0;
    localparam logic [1:0] CFG_GYRO_DZ    = 2'd1;
    localparam logic [1:0] CFG_MAX_ROUNDS = 2'd2;

    // Item function codes
    localparam logic FUNC_START  = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    // Calibration progress
    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_FIRST  = 2'd1,
        PH_REFINE = 2'd2,
        PH_DONE   = 2'd3
    } phase_t;

    typedef struct packed {
        logic               func;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
    } item_t;

    typedef struct packed {
        logic signed [15:0] off_accel_x;
        logic signed [15:0] off_accel_y;
        logic signed [15:0] off_accel_z;
        logic signed [15:0] off_gyro_x;
        logic signed [15:0] off_gyro_y;
        logic signed [15:0] off_gyro_z;
        logic [3:0]         round_number;
        logic               done_res;
        logic               converged;
    } res_t;

    // Clamp an 18-bit signed value to 16 bits
    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > 18'sd32767)
            r = 16'sh7FFF;
        else if (v < -18'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

endpackage

// ===== sv/imu_offset_calibrator.sv =====
// Six-axis offset calibrator: sample averaging, shared divider and offset update.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+----------------------------
//  in       | in        | in_valid / in_stall  | in_item  (imuoc_pkg::item_t)
//  out      | out       | out_valid / out_stall| out_item (imuoc_pkg::res_t)
//  cfg      | in        | cfg_we               | cfg_index, cfg_data
//
// A summed sample is added one axis at a time (one shared adder walks the six axes). The
// sample that closes a round adds, then takes one reciprocal multiply per axis for the mean
// and, in refinement, one restoring divider pass of MAGS_W (21) steps per axis outside its
// deadzone.
// in_stall is low only while the sequencer waits for an item; a finished result
// sits in the output register and the next one holds until it is taken.
// Reset clears control state and returns registers to their defaults.
module imu_offset_calibrator (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  imuoc_pkg::item_t  in_item,
    output logic              out_valid,
    input  logic              out_stall,
    output imuoc_pkg::res_t   out_item,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [7:0]        cfg_data
);
    import imuoc_pkg::*;

    typedef enum logic [7:0] {
        S_WAIT = 8'b00000001,
        S_ACC  = 8'b00000010,
        S_LOAD = 8'b00000100,
        S_MEAN = 8'b00001000,
        S_DIV  = 8'b00010000,
        S_AXIS = 8'b00100000,
        S_FIN  = 8'b01000000,
        S_EMIT = 8'b10000000
    } state_t;

    state_t                   state_reg, state_next;
    phase_t                   phase_reg, phase_next;
    logic [7:0]               accel_dz_reg, gyro_dz_reg;
    logic [3:0]               max_rounds_reg;
    logic signed [SUM_W-1:0]  sum_reg [NUM_AXES];
    logic signed [SUM_W-1:0]  sum_next [NUM_AXES];
    logic signed [15:0]       off_reg [NUM_AXES];
    logic signed [15:0]       off_next [NUM_AXES];
    logic signed [15:0]       samp_reg [NUM_AXES];
    logic signed [15:0]       samp_next [NUM_AXES];
    logic [SIDX_W-1:0]        sidx_reg, sidx_next;
    logic [3:0]               round_reg, round_next;
    logic [2:0]               axis_reg, axis_next;
    logic [2:0]               ready_cnt_reg, ready_cnt_next;
    logic                     res_done_reg, res_done_next;
    logic                     res_conv_reg, res_conv_next;
    logic                     neg_reg, neg_next;
    logic                     corr_reg, corr_next;
    logic [MAGS_W-1:0]        quo_reg, quo_next;
    logic [DVS_W-1:0]         rem_reg, rem_next;
    logic [DVS_W-1:0]         dvs_reg, dvs_next;
    logic [DIVCNT_W-1:0]      dcnt_reg, dcnt_next;
    logic                     out_valid_reg, out_valid_next;
    res_t                     out_reg, out_next;

    logic                     in_xfer;
    logic                     is_accel;
    logic [7:0]               dz;
    logic [DVS_W-1:0]         corr_dvs;
    logic [DVS_W:0]           shifted;
    logic [DVS_W:0]           trial;
    logic [PROD_W-1:0]        mean_prod;
    logic [MAG_W-1:0]         q16;
    logic [MAG_W-1:0]         q_shift;
    logic signed [SUM_W-1:0]  cur_sum;
    logic signed [SUM_W-1:0]  abs_sum;
    logic signed [17:0]       first_val;
    logic signed [17:0]       corr_val;
    logic [3:0]               round_inc;
    logic                     all_ready;

    assign in_stall  = (state_reg != S_WAIT);
    assign in_xfer   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // Per-axis selection shared by all sequencer steps
    assign is_accel = (axis_reg < 3'(NUM_ACCEL));
    assign dz       = is_accel ? accel_dz_reg : gyro_dz_reg;
    assign corr_dvs = is_accel ? ((accel_dz_reg == 8'd0) ? DVS_W'(1) : DVS_W'(accel_dz_reg))
                               : DVS_W'({1'b0, gyro_dz_reg} + 9'd1);
    assign cur_sum  = sum_reg[axis_reg];
    assign abs_sum  = cur_sum[SUM_W-1] ? -cur_sum : cur_sum;

    // Reciprocal product for the mean of the loaded sum magnitude
    assign mean_prod = {{RECIP_W{1'b0}}, quo_reg} * {{MAGS_W{1'b0}}, RECIP_W'(MEAN_RECIP)};

    // Restoring divider step
    assign shifted = {rem_reg, quo_reg[MAGS_W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};

    // Quotient views for the offset update
    assign q16       = quo_reg[MAG_W-1:0];
    assign q_shift   = is_accel ? (q16 >> 3) : (q16 >> 2);
    assign first_val = neg_reg ? $signed({2'b00, q_shift}) : -$signed({2'b00, q_shift});
    assign corr_val  = neg_reg ? ($signed({{2{off_reg[axis_reg][15]}}, off_reg[axis_reg]})
                                  + $signed({2'b00, q16}))
                               : ($signed({{2{off_reg[axis_reg][15]}}, off_reg[axis_reg]})
                                  - $signed({2'b00, q16}));
    assign round_inc = round_reg + 4'd1;
    assign all_ready = (ready_cnt_reg == 3'(NUM_AXES));

    // Sequencer and datapath next state
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        sum_next       = sum_reg;
        off_next       = off_reg;
        samp_next      = samp_reg;
        sidx_next      = sidx_reg;
        round_next     = round_reg;
        axis_next      = axis_reg;
        ready_cnt_next = ready_cnt_reg;
        res_done_next  = res_done_reg;
        res_conv_next  = res_conv_reg;
        neg_next       = neg_reg;
        corr_next      = corr_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        dvs_next       = dvs_reg;
        dcnt_next      = dcnt_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        // Drop the result register once its transfer completes
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_WAIT:
            begin
                if (in_xfer)
                begin
                    if (in_item.func == FUNC_START)
                    begin
                        // Restart from scratch and report zero offsets
                        for (int k = 0; k < NUM_AXES; k++)
                        begin
                            sum_next[k] = '0;
                            off_next[k] = '0;
                        end
                        sidx_next     = '0;
                        round_next    = '0;
                        phase_next    = PH_FIRST;
                        res_done_next = 1'b0;
                        res_conv_next = 1'b0;
                        state_next    = S_EMIT;
                    end
                    else if (phase_reg == PH_FIRST || phase_reg == PH_REFINE)
                    begin
                        samp_next[0] = in_item.accel_x;
                        samp_next[1] = in_item.accel_y;
                        samp_next[2] = in_item.accel_z;
                        samp_next[3] = in_item.gyro_x;
                        samp_next[4] = in_item.gyro_y;
                        samp_next[5] = in_item.gyro_z;
                        if (sidx_reg > SIDX_W'(DISCARD))
                        begin
                            axis_next  = '0;
                            state_next = S_ACC;
                        end
                        else
                            sidx_next = sidx_reg + SIDX_W'(1);
                    end
                end
            end

            S_ACC:
            begin
                // Add one axis per cycle
                sum_next[axis_reg] = cur_sum + SUM_W'(samp_reg[axis_reg]);
                if (axis_reg == 3'(NUM_AXES - 1))
                begin
                    axis_next = '0;
                    if (sidx_reg == SIDX_W'(SIDX_END))
                    begin
                        sidx_next      = '0;
                        ready_cnt_next = '0;
                        state_next     = S_LOAD;
                    end
                    else
                    begin
                        sidx_next  = sidx_reg + SIDX_W'(1);
                        state_next = S_WAIT;
                    end
                end
                else
                    axis_next = axis_reg + 3'd1;
            end

            S_LOAD:
            begin
                // Latch the sum magnitude and sign for this axis and clear its sum
                neg_next           = cur_sum[SUM_W-1];
                quo_next           = abs_sum[MAGS_W-1:0];
                corr_next          = 1'b0;
                sum_next[axis_reg] = '0;
                state_next         = S_MEAN;
            end

            S_MEAN:
            begin
                // Mean magnitude by reciprocal multiply
                quo_next   = MAGS_W'(mean_prod >> MEAN_SHIFT);
                state_next = S_AXIS;
            end

            S_DIV:
            begin
                if (!trial[DVS_W])
                begin
                    rem_next = trial[DVS_W-1:0];
                    quo_next = {quo_reg[MAGS_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = shifted[DVS_W-1:0];
                    quo_next = {quo_reg[MAGS_W-2:0], 1'b0};
                end
                dcnt_next = dcnt_reg + DIVCNT_W'(1);
                if (dcnt_reg == DIVCNT_W'(MAGS_W - 1))
                    state_next = S_AXIS;
            end

            S_AXIS:
            begin
                if (!corr_reg && phase_reg == PH_FIRST)
                begin
                    off_next[axis_reg] = sat16(first_val);
                    state_next         = S_FIN;
                end
                else if (!corr_reg && ({8'd0, q16} <= {8'd0, 8'd0, dz}))
                begin
                    ready_cnt_next = ready_cnt_reg + 3'd1;
                    state_next     = S_FIN;
                end
                else if (!corr_reg)
                begin
                    // Axis outside its deadzone: divide the mean by the correction divisor
                    quo_next   = MAGS_W'(q16);
                    rem_next   = '0;
                    dvs_next   = corr_dvs;
                    dcnt_next  = '0;
                    corr_next  = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    off_next[axis_reg] = sat16(corr_val);
                    state_next         = S_FIN;
                end
                // Advance to the next axis unless a division follows
                if (state_next == S_FIN && axis_reg != 3'(NUM_AXES - 1))
                begin
                    axis_next  = axis_reg + 3'd1;
                    state_next = S_LOAD;
                end
            end

            S_FIN:
            begin
                axis_next = '0;
                if (phase_reg == PH_FIRST)
                begin
                    res_conv_next = 1'b0;
                    if (max_rounds_reg == 4'd0)
                    begin
                        phase_next    = PH_DONE;
                        res_done_next = 1'b1;
                    end
                    else
                    begin
                        phase_next    = PH_REFINE;
                        res_done_next = 1'b0;
                    end
                end
                else
                begin
                    round_next = round_inc;
                    if (all_ready || round_inc >= max_rounds_reg)
                    begin
                        phase_next    = PH_DONE;
                        res_done_next = 1'b1;
                        res_conv_next = all_ready;
                    end
                    else
                    begin
                        res_done_next = 1'b0;
                        res_conv_next = 1'b0;
                    end
                end
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                // Hold until the result register is free
                if (!(out_valid_reg && out_stall))
                begin
                    out_next.off_accel_x  = off_reg[0];
                    out_next.off_accel_y  = off_reg[1];
                    out_next.off_accel_z  = off_reg[2];
                    out_next.off_gyro_x   = off_reg[3];
                    out_next.off_gyro_y   = off_reg[4];
                    out_next.off_gyro_z   = off_reg[5];
                    out_next.round_number = round_reg;
                    out_next.done_res     = res_done_reg;
                    out_next.converged    = res_conv_reg;
                    out_valid_next        = 1'b1;
                    state_next            = S_WAIT;
                end
            end

            default:
            begin
                state_next = S_WAIT;
            end
        endcase
    end

    // Control state and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_WAIT;
            phase_reg      <= PH_IDLE;
            sidx_reg       <= '0;
            round_reg      <= '0;
            axis_reg       <= '0;
            ready_cnt_reg  <= '0;
            res_done_reg   <= 1'b0;
            res_conv_reg   <= 1'b0;
            corr_reg       <= 1'b0;
            dcnt_reg       <= '0;
            out_valid_reg  <= 1'b0;
            accel_dz_reg   <= ACCEL_DZ_RST;
            gyro_dz_reg    <= GYRO_DZ_RST;
            max_rounds_reg <= MAX_ROUNDS_RST;
            for (int k = 0; k < NUM_AXES; k++)
            begin
                sum_reg[k] <= '0;
                off_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            sidx_reg      <= sidx_next;
            round_reg     <= round_next;
            axis_reg      <= axis_next;
            ready_cnt_reg <= ready_cnt_next;
            res_done_reg  <= res_done_next;
            res_conv_reg  <= res_conv_next;
            corr_reg      <= corr_next;
            dcnt_reg      <= dcnt_next;
            out_valid_reg <= out_valid_next;
            sum_reg       <= sum_next;
            off_reg       <= off_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_ACCEL_DZ:   accel_dz_reg   <= cfg_data;
                    CFG_GYRO_DZ:    gyro_dz_reg    <= cfg_data;
                    CFG_MAX_ROUNDS: max_rounds_reg <= cfg_data[3:0];
                    default:        ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        samp_reg <= samp_next;
        neg_reg  <= neg_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        out_reg  <= out_next;
    end

    // The ready count covers six axes at most
    assert property (@(posedge clk) disable iff (!rst_n)
        ready_cnt_reg <= 3'(NUM_AXES))
        else $error("ready count above axis count");

    // The divider only runs while a calibration is in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> (phase_reg == PH_FIRST || phase_reg == PH_REFINE))
        else $error("divider active outside calibration");

    // A converged result is always a final one
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.converged |-> out_reg.done_res)
        else $error("converged without done");

    // Loading a final result leaves the block finished
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT && !(out_valid_reg && out_stall) && res_done_reg
        |=> phase_reg == PH_DONE)
        else $error("final result emitted while calibration still running");

    // The sample index never passes the end of a round
    assert property (@(posedge clk) disable iff (!rst_n)
        sidx_reg <= SIDX_W'(SIDX_END))
        else $error("sample index past round end");

endmodule
